/* hw/rtl/hc3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_pkg
// Types, constants and mod 26 helpers shared by the 3x3 Hill cipher block.
// ----------------------------------------------------------------------------
package hc3_pkg;

    localparam int ALPHA = 26;

    typedef logic [4:0]            t_letter;
    typedef logic [2:0][4:0]       t_row;
    typedef logic [2:0][2:0][4:0]  t_mat;
    typedef logic [2:0][14:0]      t_key_regs;

    typedef struct packed {
        logic    action;
        t_letter letter_first;
        t_letter letter_second;
        t_letter letter_third;
    } t_hc3_in;

    typedef struct packed {
        t_letter out_first;
        t_letter out_second;
        t_letter out_third;
        logic    key_not_invertible;
        logic    bad_letter;
    } t_hc3_out;

    // Stage enables of one lane, from the shared flow control.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_hc3_lane_en;

    localparam logic [1:0]  CFG_KEY_ROW0 = 2'd0;
    localparam logic [1:0]  CFG_KEY_ROW1 = 2'd1;
    localparam logic [1:0]  CFG_KEY_ROW2 = 2'd2;

    localparam logic [14:0] KEY_ROW0_RST = 15'd1798;
    localparam logic [14:0] KEY_ROW1_RST = 15'd10765;
    localparam logic [14:0] KEY_ROW2_RST = 15'd15924;

    localparam logic        ACT_DECRYPT  = 1'b1;

    // Register stages from the key registers to the inverse matrix.
    localparam logic [3:0]  KEY_LAT      = 4'd10;

    // Remainder mod 26 of a value below 1024. The quotient estimate x*315/8192
    // is never high and at most one low, so one correction suffices.
    function automatic t_letter f_mod26(input logic [9:0] x);
        logic [18:0] p;
        logic [5:0]  q;
        logic [9:0]  r;
        p = 19'(x) * 19'd315;
        q = p[18:13];
        r = x - (10'(q) * 10'd26);
        if (r >= 10'd26) begin
            r = r - 10'd26;
        end
        return r[4:0];
    endfunction

    // Reduce a 5-bit value mod 26.
    function automatic t_letter f_red5(input t_letter x);
        return (x > 5'd25) ? (x - 5'd26) : x;
    endfunction

    // Multiplicative inverse mod 26; zero when none exists.
    function automatic t_letter f_inv26(input t_letter d);
        t_letter r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/hc3_key_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_key_unit
// Reduces the key entries mod 26 and derives the inverse key matrix
// (adjugate times inverse determinant) through a register pipeline.
// ----------------------------------------------------------------------------
module hc3_key_unit
    import hc3_pkg::*;
(
    input  logic      i_clk,
    input  t_key_regs i_key,
    output t_mat      o_key,
    output t_mat      o_inv,
    output logic      o_key_ok
);

    t_mat                 r_k;
    logic [2:0][2:0][9:0] r_pa;
    logic [2:0][2:0][9:0] r_pb;
    t_mat                 r_ma;
    t_mat                 r_mb;
    t_mat                 r_cof;
    logic [2:0][9:0]      r_dp;
    t_row                 r_dm;
    t_letter              r_det;
    t_letter              r_dinv;
    logic [2:0][2:0][9:0] r_mp;
    t_mat                 r_minv;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_k[i][j] <= f_red5(i_key[i][j*5 +: 5]);
            end
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;

            logic [5:0] w_diff;
            assign w_diff = {1'b0, r_ma[gi][gj]} + 6'd26 - {1'b0, r_mb[gi][gj]};

            always_ff @(posedge i_clk) begin
                r_pa[gi][gj]   <= 10'(r_k[I1][J1]) * 10'(r_k[I2][J2]);
                r_pb[gi][gj]   <= 10'(r_k[I1][J2]) * 10'(r_k[I2][J1]);
                r_ma[gi][gj]   <= f_mod26(r_pa[gi][gj]);
                r_mb[gi][gj]   <= f_mod26(r_pb[gi][gj]);
                r_cof[gi][gj]  <= (w_diff >= 6'd26) ? 5'(w_diff - 6'd26) : w_diff[4:0];
                // Adjugate is the transposed cofactor matrix.
                r_mp[gi][gj]   <= 10'(r_cof[gj][gi]) * 10'(r_dinv);
                r_minv[gi][gj] <= f_mod26(r_mp[gi][gj]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_dp[j] <= 10'(r_k[0][j]) * 10'(r_cof[0][j]);
            r_dm[j] <= f_mod26(r_dp[j]);
        end
        r_det  <= f_mod26(10'(r_dm[0]) + 10'(r_dm[1]) + 10'(r_dm[2]));
        r_dinv <= f_inv26(r_det);
    end

    assign o_key    = r_k;
    assign o_inv    = r_minv;
    assign o_key_ok = (r_dinv != 5'd0);

endmodule

/* hw/rtl/hc3_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_lane
// One output letter: dot product of a matrix row with the letter vector,
// reduced mod 26, in three register stages.
// ----------------------------------------------------------------------------
module hc3_lane
    import hc3_pkg::*;
(
    input  logic         i_clk,
    input  t_hc3_lane_en i_en,
    input  t_row         i_row,
    input  t_row         i_vec,
    output t_letter      o_res
);

    logic [2:0][9:0] r_prod;
    t_row            r_pm;
    t_letter         r_res;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= 10'(i_row[j]) * 10'(i_vec[j]);
            end
        end
        if (i_en.s2) begin
            for (int j = 0; j < 3; j++) begin
                r_pm[j] <= f_mod26(r_prod[j]);
            end
        end
        if (i_en.s3) begin
            r_res <= f_mod26(10'(r_pm[0]) + 10'(r_pm[1]) + 10'(r_pm[2]));
        end
    end

    assign o_res = r_res;

endmodule

/* hw/rtl/hill_cipher_3x3_mod26_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26_top
// Hill cipher on blocks of three letters with a 3x3 key mod 26: three row
// lanes, a key unit that derives the inverse key, and an output merge stage.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Moves
//  ---------+-------------------------------------------+----------------------
//  input    | i_in_valid, o_in_ready, i_in_data         | action and 3 letters
//  output   | o_out_valid, i_out_ready, o_out_data      | 3 letters and flags
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | key rows 0..2
//
// One transaction enters per cycle unless the output stalls or the key is
// settling; each result passes through the input register, three lane
// stages and merge register, five registers in all.
// After reset and after every configuration write the input is held off
// while the key unit pipeline recomputes the inverse key.
// A stalled output stops only the stages behind a full stage; bubbles close up.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26_top
    import hc3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_hc3_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_hc3_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    t_key_regs    r_key;
    logic [3:0]   r_settle;
    logic [4:0]   r_vld;
    logic [4:0]   w_en;
    logic         w_in_acc;

    logic         r_s0_act;
    logic         r_s0_bad;
    t_row         r_s0_vec;
    logic [2:0]   r_act;
    logic [2:0]   r_bad;
    t_hc3_out     r_out;

    t_mat         w_key;
    t_mat         w_inv;
    logic         w_key_ok;
    t_hc3_lane_en w_lane_en;
    t_row         w_res;
    logic         w_ok;

    // Key registers and settle counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_ROW0_RST;
            r_key[1] <= KEY_ROW1_RST;
            r_key[2] <= KEY_ROW2_RST;
            r_settle <= KEY_LAT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_ROW0: r_key[0] <= i_cfg_data;
                    CFG_KEY_ROW1: r_key[1] <= i_cfg_data;
                    CFG_KEY_ROW2: r_key[2] <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= KEY_LAT;
            end else if (r_settle != 4'd0) begin
                r_settle <= r_settle - 4'd1;
            end
        end
    end

    hc3_key_unit u_key (
        .i_clk    (i_clk),
        .i_key    (r_key),
        .o_key    (w_key),
        .o_inv    (w_inv),
        .o_key_ok (w_key_ok)
    );

    // A stage may load when it is empty or the stage after it moves on.
    always_comb begin
        w_en[4] = !r_vld[4] || i_out_ready;
        for (int k = 3; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0] && (r_settle == 4'd0);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_in_acc;
            end
            for (int k = 1; k < 5; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Input register: letters reduced mod 26, out-of-range flag.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_act    <= i_in_data.action;
            r_s0_bad    <= (i_in_data.letter_first  > 5'd25) ||
                           (i_in_data.letter_second > 5'd25) ||
                           (i_in_data.letter_third  > 5'd25);
            r_s0_vec[0] <= f_red5(i_in_data.letter_first);
            r_s0_vec[1] <= f_red5(i_in_data.letter_second);
            r_s0_vec[2] <= f_red5(i_in_data.letter_third);
        end
    end

    // Action and letter flag ride along with the lane stages.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_act[0] <= r_s0_act;
            r_bad[0] <= r_s0_bad;
        end
        for (int k = 1; k < 3; k++) begin
            if (w_en[k+1]) begin
                r_act[k] <= r_act[k-1];
                r_bad[k] <= r_bad[k-1];
            end
        end
    end

    assign w_lane_en = '{s1: w_en[1], s2: w_en[2], s3: w_en[3]};

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
        t_row w_row;
        assign w_row = (r_s0_act == ACT_DECRYPT) ? w_inv[gl] : w_key[gl];

        hc3_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_lane_en),
            .i_row (w_row),
            .i_vec (r_s0_vec),
            .o_res (w_res[gl])
        );
    end

    // Merge stage: a decrypt with a singular key gives zero letters and a flag.
    assign w_ok = (r_act[2] != ACT_DECRYPT) || w_key_ok;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_out.out_first          <= w_ok ? w_res[0] : 5'd0;
            r_out.out_second         <= w_ok ? w_res[1] : 5'd0;
            r_out.out_third          <= w_ok ? w_res[2] : 5'd0;
            r_out.key_not_invertible <= !w_ok;
            r_out.bad_letter         <= r_bad[2];
        end
    end

    assign o_out_valid = r_vld[4];
    assign o_out_data  = r_out;

endmodule
